[rtl/core/npstep_pkg.sv]
// Shared types and constants for the next-permutation step engine.
// No dependencies; every other file in rtl/core imports this package.
package npstep_pkg;

  localparam int unsigned POS_W    = 3;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned EMIT_MAX = 8;

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  typedef struct packed {
    req_t              kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    logic              advanced;
    logic              last;
  } res_t;

endpackage

[rtl/core/npstep_front.sv]
// Front end: accepts input transactions, holds the length register and
// classifies each item into a command for the queue. Depends on npstep_pkg.
module npstep_front import npstep_pkg::*; #(
  parameter int unsigned MAX_LEN    = 8,
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [POS_W-1:0] in_load_position,
  input  logic [VAL_W-1:0] in_load_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  localparam logic [VAL_W-1:0] VAL_MASK =
    (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((1 << VALUE_BITS) - 1);

  logic [LEN_W-1:0] seq_len_r;
  logic [LEN_W-1:0] len_eff;
  logic             accept;
  logic             pos_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= LEN_RESET;
    end else if (cfg_valid) begin
      seq_len_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign pos_ok    = (32'(in_load_position) < MAX_LEN);
  assign len_eff   = (32'(seq_len_r) > MAX_LEN) ? LEN_W'(MAX_LEN) : seq_len_r;

  assign push = accept && ((req_t'(in_req_type) == REQ_ADVANCE) || pos_ok);

  always_comb begin
    push_cmd.kind  = req_t'(in_req_type);
    push_cmd.pos   = in_load_position;
    push_cmd.value = in_load_value & VAL_MASK;
    push_cmd.len   = len_eff;
  end

endmodule

[rtl/core/npstep_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on npstep_pkg for the command type.
module npstep_queue import npstep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  cmd_t       slot_r [2];
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/npstep_back.sv]
// Back end: holds the sequence memory, runs pivot search, swap, tail
// reversal and emission, and owns the result register. Depends on npstep_pkg.
module npstep_back import npstep_pkg::*; #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SCAN    = 11'b000_0000_0010,
    ST_FIND    = 11'b000_0000_0100,
    ST_SWAP    = 11'b000_0000_1000,
    ST_REV_LO  = 11'b000_0001_0000,
    ST_REV_HI  = 11'b000_0010_0000,
    ST_REV_WH  = 11'b000_0100_0000,
    ST_REV_WL  = 11'b000_1000_0000,
    ST_EMIT_RD = 11'b001_0000_0000,
    ST_EMIT    = 11'b010_0000_0000,
    ST_FILL    = 11'b100_0000_0000
  } state_t;

  logic [VAL_W-1:0] mem [MAX_LEN];

  state_t           state_r, state_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    top_idx_r, top_idx_nxt;
  logic [AW-1:0]    last_idx_r, last_idx_nxt;
  logic [AW-1:0]    piv_idx_r, piv_idx_nxt;
  logic [VAL_W-1:0] piv_val_r, piv_val_nxt;
  logic [VAL_W-1:0] prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [VAL_W-1:0] hold_r, hold_nxt;
  logic [AW-1:0]    lo_r, lo_nxt;
  logic [AW-1:0]    hi_r, hi_nxt;
  logic             adv_r, adv_nxt;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rdata_r;
  logic [AW-1:0]    rtag_r;
  logic             rvld_r;
  logic             wen;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  logic             out_valid_r;
  res_t             out_res_r;
  logic             out_load;
  res_t             out_new;
  logic             out_free;

  logic [LEN_W-1:0] n_emit;
  logic [AW-1:0]    piv_inc;
  logic [AW-1:0]    lo_inc;
  logic [AW-1:0]    hi_dec;

  assign out_free = !out_valid_r || !out_stall;
  assign n_emit   = (32'(q_cmd.len) > EMIT_MAX) ? LEN_W'(EMIT_MAX) : q_cmd.len;
  assign piv_inc  = piv_idx_r + 1'b1;
  assign lo_inc   = lo_r + 1'b1;
  assign hi_dec   = hi_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    top_idx_nxt   = top_idx_r;
    last_idx_nxt  = last_idx_r;
    piv_idx_nxt   = piv_idx_r;
    piv_val_nxt   = piv_val_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    hold_nxt      = hold_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    adv_nxt       = adv_r;
    rd_en         = 1'b0;
    rd_addr       = k_r;
    wen           = 1'b0;
    waddr         = k_r;
    wdata         = hold_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_new       = out_res_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.kind == REQ_LOAD) begin
            wen   = 1'b1;
            waddr = AW'(q_cmd.pos);
            wdata = q_cmd.value;
          end else begin
            adv_nxt       = 1'b0;
            k_nxt         = '0;
            have_prev_nxt = 1'b0;
            top_idx_nxt   = AW'(32'(q_cmd.len) - 32'd1);
            last_idx_nxt  = AW'(32'(n_emit) - 32'd1);
            if (q_cmd.len == '0) begin
              state_nxt = ST_FILL;
            end else if (q_cmd.len == LEN_W'(1)) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              k_nxt     = AW'(32'(q_cmd.len) - 32'd1);
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = k_r;
        if (k_r != '0) begin
          k_nxt = k_r - 1'b1;
        end
        if (rvld_r) begin
          if (have_prev_r && (rdata_r < prev_r)) begin
            piv_idx_nxt = rtag_r;
            piv_val_nxt = rdata_r;
            k_nxt       = top_idx_r;
            rd_en       = 1'b0;
            state_nxt   = ST_FIND;
          end else if (rtag_r == '0) begin
            k_nxt     = '0;
            rd_en     = 1'b0;
            state_nxt = ST_EMIT_RD;
          end else begin
            prev_nxt      = rdata_r;
            have_prev_nxt = 1'b1;
          end
        end
      end
      ST_FIND: begin
        rd_en   = 1'b1;
        rd_addr = k_r;
        if (k_r != '0) begin
          k_nxt = k_r - 1'b1;
        end
        if (rvld_r && (rdata_r > piv_val_r)) begin
          wen       = 1'b1;
          waddr     = rtag_r;
          wdata     = piv_val_r;
          hold_nxt  = rdata_r;
          rd_en     = 1'b0;
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        wen     = 1'b1;
        waddr   = piv_idx_r;
        wdata   = hold_r;
        adv_nxt = 1'b1;
        lo_nxt  = piv_inc;
        hi_nxt  = top_idx_r;
        if (piv_inc < top_idx_r) begin
          state_nxt = ST_REV_LO;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_REV_LO: begin
        rd_en     = 1'b1;
        rd_addr   = lo_r;
        state_nxt = ST_REV_HI;
      end
      ST_REV_HI: begin
        rd_en     = 1'b1;
        rd_addr   = hi_r;
        hold_nxt  = rdata_r;
        state_nxt = ST_REV_WH;
      end
      ST_REV_WH: begin
        wen       = 1'b1;
        waddr     = hi_r;
        wdata     = hold_r;
        state_nxt = ST_REV_WL;
      end
      ST_REV_WL: begin
        wen    = 1'b1;
        waddr  = lo_r;
        wdata  = rdata_r;
        lo_nxt = lo_inc;
        hi_nxt = hi_dec;
        if (lo_inc < hi_dec) begin
          state_nxt = ST_REV_LO;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_new.value    = rdata_r;
          out_new.pos      = POS_W'(k_r);
          out_new.advanced = adv_r;
          out_new.last     = (k_r == last_idx_r);
          if (k_r == last_idx_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt   = k_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = k_r + 1'b1;
          end
        end
      end
      ST_FILL: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_new.value    = '0;
          out_new.pos      = '0;
          out_new.advanced = 1'b0;
          out_new.last     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvld_r  <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    top_idx_r   <= top_idx_nxt;
    last_idx_r  <= last_idx_nxt;
    piv_idx_r   <= piv_idx_nxt;
    piv_val_r   <= piv_val_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    hold_r      <= hold_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    adv_r       <= adv_nxt;
    if (out_load) begin
      out_res_r <= out_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rtag_r  <= rd_addr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[rtl/core/next_permutation_step_top.sv]
// A load passes through the command queue before it is written to the sequence memory; loads
// follow at one per cycle while the back end is idle. Output stalls delay the results of an
// advance, and the next item is taken in the cycle after its last result is loaded.
// Reset (synchronous, active low) clears control state and sets the length to 8; the
// sequence memory is not cleared.
module next_permutation_step_top import npstep_pkg::*; #(
  parameter int unsigned MAX_LEN    = 8,
  parameter int unsigned VALUE_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [POS_W-1:0] in_load_position,
  input  logic [VAL_W-1:0] in_load_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_elem_value,
  output logic [POS_W-1:0] out_elem_position,
  output logic             out_advanced,
  output logic             out_last_elem,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;
  res_t out_res;

  npstep_front #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_load_position (in_load_position),
    .in_load_value    (in_load_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  npstep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  npstep_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_elem_value    = out_res.value;
  assign out_elem_position = out_res.pos;
  assign out_advanced      = out_res.advanced;
  assign out_last_elem     = out_res.last;

endmodule

[dv/next_permutation_step_top_tb.sv]
// Self-checking testbench for next_permutation_step_top: directed and random load and
// advance traffic under random sender gaps and receiver stalls, checked against a local model.
// Depends on npstep_pkg and the next_permutation_step_top RTL.
module next_permutation_step_top_tb;
  import npstep_pkg::*;

  localparam int unsigned SEQ_DEPTH   = 8;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned IDLE_PAUSE  = 50;

  typedef struct packed {
    req_t             kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } step_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = 1'b0;
  logic [POS_W-1:0] in_load_position = '0;
  logic [VAL_W-1:0] in_load_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_elem_value;
  logic [POS_W-1:0] out_elem_position;
  logic             out_advanced;
  logic             out_last_elem;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  step_item_t       stim_q[$];
  res_t             elem_exp_q[$];
  step_item_t       cur_item;
  logic [VAL_W-1:0] perm_seq [SEQ_DEPTH];
  logic [LEN_W-1:0] len_setting = LEN_RESET;
  int               items_in_flight = 0;
  int               err_count = 0;
  int               cycle_cnt = 0;
  int               burst_left = 1;
  int               gap_left = 0;
  int               stall_mode = 0;

  logic [LEN_W-1:0] phase_lens [12] = '{4'd3, 4'd8, 4'd15, 4'd4, 4'd2, 4'd9,
                                        4'd5, 4'd0, 4'd6, 4'd7, 4'd1, 4'd12};

  next_permutation_step_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_load_position  (in_load_position),
    .in_load_value     (in_load_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_elem_value    (out_elem_value),
    .out_elem_position (out_elem_position),
    .out_advanced      (out_advanced),
    .out_last_elem     (out_last_elem),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one accepted transaction to the local sequence copy and queue the elements it emits.
  function automatic void apply_perm_step(input step_item_t it);
    int unsigned      eff_len;
    int unsigned      piv;
    int unsigned      sw;
    int unsigned      lo;
    int unsigned      hi;
    logic [VAL_W-1:0] tmp;
    bit               moved;
    res_t             r;
    if (it.kind == REQ_LOAD) begin
      perm_seq[it.pos] = it.value;
      return;
    end
    eff_len = (len_setting > SEQ_DEPTH) ? SEQ_DEPTH : len_setting;
    moved = 1'b0;
    if (eff_len >= 2) begin
      piv = eff_len - 1;
      while (piv > 0) begin
        if (perm_seq[piv-1] < perm_seq[piv]) begin
          moved = 1'b1;
          break;
        end
        piv--;
      end
      if (moved) begin
        piv = piv - 1;
        sw = eff_len - 1;
        while (perm_seq[sw] <= perm_seq[piv])
          sw--;
        tmp = perm_seq[piv];
        perm_seq[piv] = perm_seq[sw];
        perm_seq[sw] = tmp;
        lo = piv + 1;
        hi = eff_len - 1;
        while (lo < hi) begin
          tmp = perm_seq[lo];
          perm_seq[lo] = perm_seq[hi];
          perm_seq[hi] = tmp;
          lo++;
          hi--;
        end
      end
    end
    if (eff_len == 0) begin
      r = '{value: '0, pos: '0, advanced: 1'b0, last: 1'b1};
      elem_exp_q.insert(elem_exp_q.size(), r);
      return;
    end
    for (int unsigned k = 0; k < eff_len; k++) begin
      r.value    = perm_seq[k];
      r.pos      = POS_W'(k);
      r.advanced = moved;
      r.last     = (k + 1 == eff_len);
      elem_exp_q.insert(elem_exp_q.size(), r);
    end
  endfunction

  function automatic logic [VAL_W-1:0] fresh_value(input int mode, input int slot);
    case (mode)
      0: return VAL_W'($urandom);
      1: return VAL_W'($urandom_range(0, 3));
      default: return VAL_W'(240 - 30 * slot);
    endcase
  endfunction

  task automatic queue_item(input req_t kind, input int pos, input logic [VAL_W-1:0] value);
    step_item_t it;
    it.kind  = kind;
    it.pos   = POS_W'(pos);
    it.value = value;
    stim_q.insert(stim_q.size(), it);
    items_in_flight++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (items_in_flight != 0 || elem_exp_q.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_seq_length(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_setting = v;
  endtask

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10)
      $display("%s", msg);
  endtask

  // Sender: bursts of random length separated by random gaps; a stalled payload is held.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_perm_step(cur_item);
        items_in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          in_valid         <= 1'b1;
          in_req_type      <= cur_item.kind;
          in_load_position <= cur_item.pos;
          in_load_value    <= cur_item.value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted element and stalls on a pattern that changes mode.
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (elem_exp_q.size() == 0) begin
          report_error($sformatf("unexpected element at cycle %0d: value %0d pos %0d",
                                 cycle_cnt, out_elem_value, out_elem_position));
        end else begin
          exp_r = elem_exp_q.pop_front();
          if (out_elem_value !== exp_r.value || out_elem_position !== exp_r.pos ||
              out_advanced !== exp_r.advanced || out_last_elem !== exp_r.last)
            report_error($sformatf({"mismatch at cycle %0d: expected value %0d pos %0d ",
                                    "adv %0b last %0b, got value %0d pos %0d adv %0b last %0b"},
                                   cycle_cnt, exp_r.value, exp_r.pos, exp_r.advanced,
                                   exp_r.last, out_elem_value, out_elem_position,
                                   out_advanced, out_last_elem));
        end
      end
      if (cycle_cnt % 64 == 0)
        stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ((cycle_cnt % 5) < 2);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("next_permutation_step_top regression: fail");
      $finish;
    end
  end

  initial begin
    int vmode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Descending sequence at the reset length of eight: already the last permutation.
    queue_item(REQ_LOAD, 0, 8'd255);
    queue_item(REQ_LOAD, 1, 8'd200);
    queue_item(REQ_LOAD, 2, 8'd150);
    queue_item(REQ_LOAD, 3, 8'd100);
    queue_item(REQ_LOAD, 4, 8'd50);
    queue_item(REQ_LOAD, 5, 8'd20);
    queue_item(REQ_LOAD, 6, 8'd1);
    queue_item(REQ_LOAD, 7, 8'd0);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    queue_item(REQ_LOAD, 7, 8'd255);
    queue_item(REQ_ADVANCE, 7, 8'd255);
    queue_item(REQ_LOAD, 0, 8'd0);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    wait_idle();

    write_seq_length(4'd0);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    queue_item(REQ_LOAD, 5, 8'd7);
    wait_idle();

    write_seq_length(4'd1);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    wait_idle();

    // Equal pair has no successor; then a rising pair advances once and stops.
    write_seq_length(4'd2);
    queue_item(REQ_LOAD, 0, 8'd9);
    queue_item(REQ_LOAD, 1, 8'd9);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    queue_item(REQ_LOAD, 1, 8'd10);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    wait_idle();

    write_seq_length(4'd15);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    wait_idle();

    write_seq_length(4'd9);
    queue_item(REQ_ADVANCE, 0, 8'd0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      write_seq_length(phase_lens[ph]);
      vmode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0)
        for (int k = 0; k < SEQ_DEPTH; k++)
          queue_item(REQ_LOAD, k, fresh_value(vmode, k));
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_item(REQ_ADVANCE, $urandom_range(0, 7), VAL_W'($urandom));
        end else begin
          vmode = $urandom_range(0, 2);
          begin
            int p;
            p = $urandom_range(0, 7);
            queue_item(REQ_LOAD, p, fresh_value(vmode, p));
          end
        end
      end
      wait_idle();
    end

    if (err_count == 0 && elem_exp_q.size() == 0) begin
      $display("next_permutation_step_top regression: pass");
    end else begin
      $display("next_permutation_step_top regression: fail");
    end
    $finish;
  end

endmodule
